>>> hdl/obw_pkg.sv
// Shared constants, types and the arctangent table for orientation_bin_weights.
// No dependencies.
package obw_pkg;

   localparam int ORIENTATIONS = 4;
   localparam int N_EFF = (ORIENTATIONS < 2) ? 2 : ((ORIENTATIONS > 16) ? 16 : ORIENTATIONS);
   localparam int STEPS = 16;
   localparam int IDX_W = 4;
   localparam int SPAN = N_EFF * 65536;
   localparam logic signed [32:0] COS_START = 33'sd652032874;
   localparam logic [15:0] ONE_Q15 = 16'h8000;

   typedef logic [IDX_W-1:0] idx_type;

   typedef struct packed {
      logic        valid;
      logic        zero;
      logic [15:0] angle;
   } vec_rsp_type;

   typedef struct packed {
      logic        valid;
      logic        kill;
      logic        last;
      idx_type     idx;
      logic [14:0] w;
   } cos_req_type;

   typedef struct packed {
      logic        valid;
      logic        last;
      idx_type     idx;
      logic [15:0] weight;
   } cos_rsp_type;

   // atan(2^-k), pi = 65536 units
   function automatic logic [15:0] atan_lut(int k);
      logic [15:0] r;
      case (k)
         0:       r = 16'd16384;
         1:       r = 16'd9672;
         2:       r = 16'd5110;
         3:       r = 16'd2594;
         4:       r = 16'd1302;
         5:       r = 16'd652;
         6:       r = 16'd326;
         7:       r = 16'd163;
         8:       r = 16'd81;
         9:       r = 16'd41;
         10:      r = 16'd20;
         11:      r = 16'd10;
         12:      r = 16'd5;
         13:      r = 16'd3;
         default: r = 16'd1;
      endcase
      return r;
   endfunction

endpackage

>>> hdl/obw_vec_cordic.sv
// Pipelined vectoring CORDIC: angle of the input vector modulo pi.
// Depends on obw_pkg.
module obw_vec_cordic (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic signed [15:0]   dir_x,
   input  logic signed [15:0]   dir_y,
   input  logic                 take,
   output obw_pkg::vec_rsp_type vec_out
);
   import obw_pkg::*;

   logic               v_ff    [STEPS+1];
   logic               zero_ff [STEPS+1];
   logic signed [32:0] x_ff    [STEPS+1];
   logic signed [32:0] y_ff    [STEPS+1];
   logic [15:0]        z_ff    [STEPS+1];

   logic               vadv;
   logic signed [16:0] px, py, qx, qy, rx, ry;
   logic [15:0]        rz;
   logic signed [32:0] x_in, y_in;

   assign vadv     = !v_ff[STEPS] || take;
   assign in_ready = vadv;

   always_comb begin
      px = 17'(dir_x);
      py = 17'(dir_y);
      if (py < 0 || (py == 0 && px < 0)) begin
         qx = -px;
         qy = -py;
      end else begin
         qx = px;
         qy = py;
      end
      if (qx < 0) begin
         rx = qy;
         ry = -qx;
         rz = 16'h8000;
      end else begin
         rx = qx;
         ry = qy;
         rz = 16'h0000;
      end
      x_in = 33'(rx) <<< 14;
      y_in = 33'(ry) <<< 14;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (vadv) begin
         v_ff[0] <= in_valid;
      end
      if (vadv) begin
         zero_ff[0] <= (dir_x == 16'sd0) && (dir_y == 16'sd0);
         x_ff[0]    <= x_in;
         y_ff[0]    <= y_in;
         z_ff[0]    <= rz;
      end
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_stage
      logic signed [32:0] xs, ys;
      assign xs = x_ff[k] >>> k;
      assign ys = y_ff[k] >>> k;
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (vadv) begin
            v_ff[k+1] <= v_ff[k];
         end
         if (vadv) begin
            zero_ff[k+1] <= zero_ff[k];
            if (y_ff[k] > 0) begin
               x_ff[k+1] <= x_ff[k] + ys;
               y_ff[k+1] <= y_ff[k] - xs;
               z_ff[k+1] <= z_ff[k] + atan_lut(k);
            end else begin
               x_ff[k+1] <= x_ff[k] - ys;
               y_ff[k+1] <= y_ff[k] + xs;
               z_ff[k+1] <= z_ff[k] - atan_lut(k);
            end
         end
      end
   end

   assign vec_out.valid = v_ff[STEPS];
   assign vec_out.zero  = zero_ff[STEPS];
   assign vec_out.angle = z_ff[STEPS];

endmodule

>>> hdl/obw_expand.sv
// Per-orientation sequencer: one line distance per cycle while adv is high, for each held angle.
// Depends on obw_pkg.
module obw_expand (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  obw_pkg::vec_rsp_type vec_in,
   output logic                 take,
   output obw_pkg::cos_req_type cos_out
);
   import obw_pkg::*;

   localparam logic [20:0] SPAN_V = 21'(SPAN);
   localparam idx_type     LAST_IDX = IDX_W'(N_EFF - 1);

   logic        busy_ff, zero_ff;
   idx_type     idx_ff;
   logic [15:0] a_ff;
   cos_req_type cos_ff;

   logic [20:0] na, off, u, ldist;
   logic        is_last;

   always_comb begin
      na   = 21'(N_EFF) * {5'd0, a_ff};
      off  = {1'b0, idx_ff, 16'd0};
      if (na < off) begin
         u = na + SPAN_V - off;
      end else begin
         u = na - off;
      end
      ldist = ((SPAN_V - u) < u) ? (SPAN_V - u) : u;
      is_last = (idx_ff == LAST_IDX);
   end

   assign take = adv && (!busy_ff || is_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         cos_ff.valid <= 1'b0;
      end else if (adv) begin
         cos_ff.valid <= busy_ff;
         if (take) begin
            busy_ff <= vec_in.valid;
         end
      end
      if (adv) begin
         cos_ff.kill <= zero_ff || (ldist >= 21'd65536);
         cos_ff.last <= is_last;
         cos_ff.idx  <= idx_ff;
         cos_ff.w    <= ldist[15:1];
         if (take) begin
            idx_ff  <= '0;
            a_ff    <= vec_in.angle;
            zero_ff <= vec_in.zero;
         end else if (busy_ff) begin
            idx_ff <= idx_ff + 1'b1;
         end
      end
   end

   assign cos_out = cos_ff;

endmodule

>>> hdl/obw_cos_cordic.sv
// Pipelined rotation CORDIC: cos of the half line distance as rounded Q1.15.
// Depends on obw_pkg.
module obw_cos_cordic (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  obw_pkg::cos_req_type req,
   output obw_pkg::cos_rsp_type rsp
);
   import obw_pkg::*;

   logic               v_ff    [STEPS+1];
   logic               kill_ff [STEPS+1];
   logic               last_ff [STEPS+1];
   idx_type            idx_ff  [STEPS+1];
   logic signed [32:0] x_ff    [STEPS+1];
   logic signed [32:0] y_ff    [STEPS+1];
   logic signed [17:0] z_ff    [STEPS+1];

   cos_rsp_type        rsp_ff;
   logic signed [33:0] rs;
   logic signed [33:0] rq;
   logic [15:0]        wt;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= req.valid;
      end
      if (adv) begin
         kill_ff[0] <= req.kill;
         last_ff[0] <= req.last;
         idx_ff[0]  <= req.idx;
         x_ff[0]    <= COS_START;
         y_ff[0]    <= '0;
         z_ff[0]    <= {3'b000, req.w};
      end
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_stage
      logic signed [32:0] xs, ys;
      logic signed [17:0] at;
      assign xs = x_ff[k] >>> k;
      assign ys = y_ff[k] >>> k;
      assign at = 18'(atan_lut(k));
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (adv) begin
            v_ff[k+1] <= v_ff[k];
         end
         if (adv) begin
            kill_ff[k+1] <= kill_ff[k];
            last_ff[k+1] <= last_ff[k];
            idx_ff[k+1]  <= idx_ff[k];
            if (z_ff[k] >= 0) begin
               x_ff[k+1] <= x_ff[k] - ys;
               y_ff[k+1] <= y_ff[k] + xs;
               z_ff[k+1] <= z_ff[k] - at;
            end else begin
               x_ff[k+1] <= x_ff[k] + ys;
               y_ff[k+1] <= y_ff[k] - xs;
               z_ff[k+1] <= z_ff[k] + at;
            end
         end
      end
   end

   always_comb begin
      rs = 34'(x_ff[STEPS]) + 34'sd16384;
      rq = rs >>> 15;
      if (kill_ff[STEPS] || rq < 0) begin
         wt = '0;
      end else if (rq > 34'sd32768) begin
         wt = ONE_Q15;
      end else begin
         wt = rq[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ff.valid <= 1'b0;
      end else if (adv) begin
         rsp_ff.valid <= v_ff[STEPS];
      end
      if (adv) begin
         rsp_ff.last   <= last_ff[STEPS];
         rsp_ff.idx    <= idx_ff[STEPS];
         rsp_ff.weight <= wt;
      end
   end

   assign rsp = rsp_ff;

endmodule

>>> hdl/orientation_bin_weights.sv
// Orientation binning with cosine weights: vector angle, per-line weights, argmax.
// One result per cycle unless rsp_tready stalls the output; the orientation sequencer
// feeds one cos pipe, so each vector gives one result per orientation.
// A stalled result holds the whole back end; the angle pipe moves until its output holds a vector.
// Synchronous active-high reset clears all valid bits and the sequencer; no clearing pass.
// Depends on obw_pkg, obw_vec_cordic, obw_expand, obw_cos_cordic.
module orientation_bin_weights (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // dir_x[15:0], dir_y[31:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // orientation[3:0], weight[19:4], winner[23:20], no_winner[24]
   output logic        rsp_tlast
);
   import obw_pkg::*;

   logic        adv, take;
   vec_rsp_type vec;
   cos_req_type creq;
   cos_rsp_type crsp;

   logic        valid_ff, last_ff, no_win_ff;
   idx_type     orient_ff, winner_ff, win_ff;
   logic [15:0] weight_ff, best_ff;

   logic [15:0] prev_best, new_best;
   idx_type     prev_win, new_win;
   logic        gt;

   assign adv = !valid_ff || rsp_tready;

   obw_vec_cordic u_vec (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .dir_x    (req_tdata[15:0]),
      .dir_y    (req_tdata[31:16]),
      .take     (take),
      .vec_out  (vec)
   );

   obw_expand u_exp (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .vec_in  (vec),
      .take    (take),
      .cos_out (creq)
   );

   obw_cos_cordic u_cos (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .req   (creq),
      .rsp   (crsp)
   );

   always_comb begin
      prev_best = (crsp.idx == '0) ? 16'd0 : best_ff;
      prev_win  = (crsp.idx == '0) ? '0 : win_ff;
      gt        = crsp.weight > prev_best;
      new_best  = gt ? crsp.weight : prev_best;
      new_win   = gt ? crsp.idx : prev_win;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= crsp.valid;
      end
      if (adv && crsp.valid) begin
         best_ff   <= new_best;
         win_ff    <= new_win;
         orient_ff <= crsp.idx;
         weight_ff <= crsp.weight;
         last_ff   <= crsp.last;
         winner_ff <= (crsp.last && new_best != 16'd0) ? new_win : '0;
         no_win_ff <= crsp.last && (new_best == 16'd0);
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {7'd0, no_win_ff, winner_ff, weight_ff, orient_ff};

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[3:0] == IDX_W'(N_EFF - 1))
      else $error("last transfer on wrong orientation");

   a_winner_only_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[24:20] == 5'd0)
      else $error("winner fields set before last transfer");

   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[19:4] <= ONE_Q15)
      else $error("weight above one");

   a_no_winner_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[24] |-> rsp_tdata[23:20] == 4'd0)
      else $error("winner index with no winner");

endmodule

>>> tb/sv/testbench.sv
// Testbench for orientation_bin_weights: directed and random direction vectors,
// per-orientation weights predicted in-bench and checked on each result transfer.
// Depends on obw_pkg and the orientation_bin_weights RTL.
`timescale 1ns / 100ps

module testbench;
   import obw_pkg::*;

   typedef struct {
      logic [3:0]  orientation;
      logic [15:0] weight;
      logic        last;
      logic [3:0]  winner;
      logic        no_winner;
   } bin_result_type;

   localparam int LIMIT = 400000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;

   bin_result_type expected_bins[$];
   int          errors = 0;
   int          cycles = 0;
   bit          idle_enable = 1;

   orientation_bin_weights uut (.*);

   always #10 clock = ~clock;

   int atan_k[16] = '{16384, 9672, 5110, 2594, 1302, 652, 326, 163,
                      81, 41, 20, 10, 5, 3, 1, 1};

   function automatic longint fshr(longint v, int k);
      return v >>> k;
   endfunction

   function automatic int vector_angle(int sx, int sy);
      longint x = sx, y = sy, t, xs, ys;
      int z = 0;
      if (y < 0 || (y == 0 && x < 0)) begin
         x = -x;
         y = -y;
      end
      if (x < 0) begin
         t = x;
         x = y;
         y = -t;
         z = 32768;
      end
      x = x * 16384;
      y = y * 16384;
      for (int k = 0; k < 16; k++) begin
         xs = fshr(x, k);
         ys = fshr(y, k);
         if (y > 0) begin
            x = x + ys;
            y = y - xs;
            z += atan_k[k];
         end else begin
            x = x - ys;
            y = y + xs;
            z -= atan_k[k];
         end
      end
      return z & 65535;
   endfunction

   function automatic int cosine_q15(int w);
      longint x = 652032874, y = 0, xs, ys, r;
      int z = w;
      for (int k = 0; k < 16; k++) begin
         xs = fshr(x, k);
         ys = fshr(y, k);
         if (z >= 0) begin
            x = x - ys;
            y = y + xs;
            z -= atan_k[k];
         end else begin
            x = x + ys;
            y = y - xs;
            z += atan_k[k];
         end
      end
      r = fshr(x + 16384, 15);
      if (r < 0) r = 0;
      if (r > 32768) r = 32768;
      return int'(r);
   endfunction

   task automatic predict_bins(logic signed [15:0] dx, logic signed [15:0] dy);
      longint span = longint'(N_EFF) * 65536;
      longint a, v, ldist;
      int w[16];
      int best = 0, win = 0;
      bit found = 0;
      bin_result_type r;
      a = (dx == 0 && dy == 0) ? 0 : vector_angle(dx, dy);
      for (int i = 0; i < N_EFF; i++) begin
         w[i] = 0;
         if (!(dx == 0 && dy == 0)) begin
            v = (N_EFF * a + span - i * 65536) % span;
            ldist = (span - v < v) ? span - v : v;
            if (ldist < 65536) w[i] = cosine_q15(int'(ldist >> 1));
            if (w[i] > best) begin
               best = w[i];
               win = i;
               found = 1;
            end
         end
      end
      for (int i = 0; i < N_EFF; i++) begin
         r.orientation = 4'(i);
         r.weight = w[i][15:0];
         r.last = (i == N_EFF - 1);
         r.winner = (r.last && found) ? 4'(win) : 4'd0;
         r.no_winner = r.last && !found;
         expected_bins.push_back(r);
      end
   endtask

   task automatic send_vector(logic [15:0] dx, logic [15:0] dy);
      while (idle_enable && $urandom_range(99) < 29) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {dy, dx};
      predict_bins(dx, dy);
      do @(posedge clock); while (!req_tready);
   endtask

   always @(posedge clock) begin
      if (!reset) rsp_tready <= !(idle_enable && $urandom_range(99) < 29);
   end

   always @(posedge clock) begin
      bin_result_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_bins.size() == 0) begin
            $display("%0t: unexpected transfer, actual %h last %b", $time, rsp_tdata, rsp_tlast);
            errors++;
         end else begin
            e = expected_bins.pop_front();
            if (rsp_tdata[3:0] !== e.orientation || rsp_tdata[19:4] !== e.weight ||
                rsp_tdata[23:20] !== e.winner || rsp_tdata[24] !== e.no_winner ||
                rsp_tdata[31:25] !== 7'd0 || rsp_tlast !== e.last)
               begin
               $display("%0t: mismatch expected o=%0d w=%0d l=%b win=%0d nw=%b actual %h last %b",
                        $time, e.orientation, e.weight, e.last, e.winner, e.no_winner,
                        rsp_tdata, rsp_tlast);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic test_extremes();
      logic [15:0] vals[7] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF,
                               16'h8000, 16'h8001, 16'h4000};
      send_vector(16'd0, 16'd0);
      for (int i = 0; i < 7; i++)
         for (int j = 0; j < 3; j++) send_vector(vals[i], vals[(i + 2 * j + 1) % 7]);
   endtask

   task automatic test_bin_boundaries();
      // exact axes and diagonals land on line centers and bin edges
      send_vector(16'd1000, 16'd0);
      send_vector(16'd0, 16'd1000);
      send_vector(16'd1000, 16'd1000);
      send_vector(-16'sd1000, 16'd1000);
   endtask

   task automatic test_random();
      logic [15:0] dx, dy;
      for (int n = 0; n < 144; n++) begin
         idle_enable = !(n >= 60 && n < 100);
         case ($urandom_range(3))
            0: begin
               dx = 16'($urandom);
               dy = 16'($urandom);
            end
            1: begin
               dx = 16'($urandom_range(15) - 8);
               dy = 16'($urandom_range(15) - 8);
            end
            2: begin
               dx = 16'($urandom);
               dy = 16'($signed(dx) >>> $urandom_range(15));
            end
            default: begin
               dx = {$urandom_range(1) ? 16'h8000 : 16'h7FFF};
               dy = 16'($urandom);
            end
         endcase
         send_vector(dx, dy);
      end
      idle_enable = 1;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 0;
      test_extremes();
      test_bin_boundaries();
      test_random();
      req_tvalid <= 0;
      while (expected_bins.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (errors == 0 && expected_bins.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
